// File: rtl/nch_pkg.sv
// Package: shared constants and types for the nearest-center histogram unit.
`timescale 1ns / 1ps
package nch_pkg;
	localparam int MAX_CLUSTERS = 64;
	localparam int MAX_DIMS     = 128;
	localparam int CW  = $clog2(MAX_CLUSTERS);
	localparam int DW  = $clog2(MAX_DIMS);
	localparam int TBL_AW = CW + DW;
	localparam int CNT_W = 10;
	localparam logic [CNT_W-1:0] CNT_MAX = 10'd1023;
	localparam int ACC_W = 40;
	localparam logic [ACC_W-1:0] DIST_INIT = 40'hFF_FFFF_FFFF;

	localparam logic [1:0] REQ_LOAD = 2'd0;
	localparam logic [1:0] REQ_DESC = 2'd1;
	localparam logic [1:0] REQ_END  = 2'd2;

	localparam logic [1:0] CFG_CLUSTERS = 2'd0;
	localparam logic [1:0] CFG_DIMS     = 2'd1;
	localparam logic [1:0] CFG_MAXDESC  = 2'd2;

	localparam logic RK_ASSIGN = 1'b0;
	localparam logic RK_BIN    = 1'b1;

	typedef struct packed {
		logic store_center;
		logic store_desc;
		logic acc_clear;
		logic acc_step;
		logic best_clear;
		logic best_update;
		logic bin_incr;
		logic bin_clear;
		logic [CW-1:0] cidx;
		logic [DW-1:0] didx;
	} nch_cmd_t;

	typedef struct packed {
		logic [CW-1:0] best_idx;
		logic [CNT_W-1:0] bin_rd;
	} nch_stat_t;
endpackage

// File: rtl/nch_datapath.sv
// Datapath: center table, descriptor buffer, distance accumulator, best tracker, histogram.
`timescale 1ns / 1ps
module nch_datapath (
	input  logic clk,
	input  logic arst_n,
	input  nch_pkg::nch_cmd_t cmd,
	input  logic [nch_pkg::CW-1:0] ld_cidx,
	input  logic [nch_pkg::DW-1:0] ld_didx,
	input  logic [15:0] ld_value,
	output nch_pkg::nch_stat_t stat
);
	logic [15:0] ctab [0:nch_pkg::MAX_CLUSTERS*nch_pkg::MAX_DIMS-1];
	logic [15:0] dbuf [0:nch_pkg::MAX_DIMS-1];
	logic [nch_pkg::CNT_W-1:0] bins_mem [0:nch_pkg::MAX_CLUSTERS-1];
	logic [nch_pkg::MAX_CLUSTERS-1:0] bin_vld_q;
	logic [nch_pkg::CNT_W-1:0] bin_rd_q;
	logic bin_rd_vld_q;
	logic [nch_pkg::CNT_W-1:0] bin_val;
	logic [15:0] ca_s1, da_s1;
	logic step_s1, step_s2;
	logic [15:0] diff_s2;
	logic [31:0] sq_s3;
	logic step_s3;
	logic [nch_pkg::ACC_W-1:0] acc_q, best_q;
	logic [nch_pkg::CW-1:0] best_idx_q;
	logic [15:0] diff;

	always_ff @(posedge clk) begin
		if (cmd.store_center) ctab[{ld_cidx, ld_didx}] <= ld_value;
		ca_s1 <= ctab[{cmd.cidx, cmd.didx}];
	end
	always_ff @(posedge clk) begin
		if (cmd.store_desc) dbuf[ld_didx] <= ld_value;
		da_s1 <= dbuf[cmd.didx];
	end

	assign diff = (da_s1 > ca_s1) ? da_s1 - ca_s1 : ca_s1 - da_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_s1 <= 1'b0;
			step_s2 <= 1'b0;
			step_s3 <= 1'b0;
		end else begin
			step_s1 <= cmd.acc_step;
			step_s2 <= step_s1;
			step_s3 <= step_s2;
		end
	end

	always_ff @(posedge clk) begin
		diff_s2 <= diff;
		sq_s3 <= diff_s2 * diff_s2;
	end

	always_ff @(posedge clk) begin
		if (cmd.acc_clear) acc_q <= '0;
		else if (step_s3) acc_q <= acc_q + {8'd0, sq_s3};
	end

	always_ff @(posedge clk) begin
		if (cmd.best_clear) begin
			best_q <= nch_pkg::DIST_INIT;
			best_idx_q <= '0;
		end else if (cmd.best_update && acc_q < best_q) begin
			best_q <= acc_q;
			best_idx_q <= cmd.cidx;
		end
	end

	assign bin_val = bin_rd_vld_q ? bin_rd_q : '0;

	always_ff @(posedge clk) begin
		if (cmd.bin_incr && bin_val != nch_pkg::CNT_MAX)
			bins_mem[best_idx_q] <= bin_val + 1'b1;
		bin_rd_q <= bins_mem[cmd.cidx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_vld_q <= '0;
			bin_rd_vld_q <= 1'b0;
		end else begin
			if (cmd.bin_clear) bin_vld_q <= '0;
			else if (cmd.bin_incr) bin_vld_q[best_idx_q] <= 1'b1;
			bin_rd_vld_q <= bin_vld_q[cmd.cidx];
		end
	end

	assign stat.best_idx = best_idx_q;
	assign stat.bin_rd = bin_val;
endmodule

// File: rtl/nch_control.sv
// Controller: request decode, search sequencing, result emission.
`timescale 1ns / 1ps
module nch_control (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [1:0] req_type,
	input  logic last_element,
	input  logic [6:0] active_clusters,
	input  logic [7:0] descriptor_dims,
	input  logic [9:0] max_descriptors,
	output nch_pkg::nch_cmd_t cmd,
	input  nch_pkg::nch_stat_t stat,
	output logic out_valid,
	input  logic out_stall,
	output logic result_kind,
	output logic [nch_pkg::CW-1:0] bin_index,
	output logic [nch_pkg::CNT_W-1:0] bin_count,
	output logic last_bin
);
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_ACC   = 3'd1;
	localparam logic [2:0] ST_DRAIN = 3'd2;
	localparam logic [2:0] ST_CMP   = 3'd3;
	localparam logic [2:0] ST_INCR  = 3'd4;
	localparam logic [2:0] ST_EMIT  = 3'd5;
	localparam logic [2:0] ST_BINS  = 3'd6;
	localparam logic [2:0] ST_BUMP  = 3'd7;

	logic [2:0] state_q;
	logic [nch_pkg::CW-1:0] c_q;
	logic [nch_pkg::DW-1:0] d_q;
	logic [2:0] wait_q;
	logic [9:0] seen_q;
	logic count_q;
	logic [nch_pkg::CW-1:0] nc_last;
	logic [nch_pkg::DW-1:0] nd_last;
	logic accept, out_free;

	assign nc_last = (active_clusters == 7'd0) ? '0 :
		(active_clusters > 7'(nch_pkg::MAX_CLUSTERS)) ? nch_pkg::CW'(nch_pkg::MAX_CLUSTERS-1) :
		nch_pkg::CW'(active_clusters - 7'd1);
	assign nd_last = (descriptor_dims == 8'd0) ? '0 :
		(descriptor_dims > 8'(nch_pkg::MAX_DIMS)) ? nch_pkg::DW'(nch_pkg::MAX_DIMS-1) :
		nch_pkg::DW'(descriptor_dims - 8'd1);

	assign out_free = !out_valid || !out_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign accept = in_valid && !in_stall;

	always_comb begin
		cmd = '0;
		cmd.cidx = c_q;
		cmd.didx = d_q;
		cmd.store_center = accept && req_type == nch_pkg::REQ_LOAD;
		cmd.store_desc = accept && req_type == nch_pkg::REQ_DESC;
		unique case (state_q)
			ST_IDLE: begin
				cmd.cidx = '0;
				cmd.acc_clear = 1'b1;
				cmd.best_clear = 1'b1;
			end
			ST_ACC: cmd.acc_step = 1'b1;
			ST_CMP: begin
				cmd.best_update = 1'b1;
				cmd.acc_clear = 1'b1;
			end
			ST_INCR: cmd.cidx = stat.best_idx;
			ST_BUMP: cmd.bin_incr = count_q;
			ST_BINS: begin
				cmd.cidx = out_free ? c_q + 1'b1 : c_q;
				cmd.bin_clear = out_free && c_q == nc_last;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			c_q <= '0;
			d_q <= '0;
			wait_q <= '0;
			seen_q <= '0;
			count_q <= 1'b0;
			out_valid <= 1'b0;
			result_kind <= nch_pkg::RK_ASSIGN;
			bin_index <= '0;
			bin_count <= '0;
			last_bin <= 1'b0;
		end else begin
			if (out_valid && !out_stall) out_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					c_q <= '0;
					d_q <= '0;
					if (accept && req_type == nch_pkg::REQ_DESC && last_element)
						state_q <= ST_ACC;
					else if (accept && req_type == nch_pkg::REQ_END)
						state_q <= ST_BINS;
				end
				ST_ACC: begin
					if (d_q == nd_last) begin
						wait_q <= 3'd4;
						state_q <= ST_DRAIN;
					end else d_q <= d_q + 1'b1;
				end
				ST_DRAIN: begin
					wait_q <= wait_q - 3'd1;
					if (wait_q == 3'd1) state_q <= ST_CMP;
				end
				ST_CMP: begin
					d_q <= '0;
					if (c_q == nc_last) state_q <= ST_INCR;
					else begin
						c_q <= c_q + 1'b1;
						state_q <= ST_ACC;
					end
				end
				ST_INCR: begin
					if (seen_q != nch_pkg::CNT_MAX) seen_q <= seen_q + 1'b1;
					state_q <= ST_BUMP;
				end
				ST_BUMP: state_q <= ST_EMIT;
				ST_EMIT: begin
					if (out_free) begin
						out_valid <= 1'b1;
						result_kind <= nch_pkg::RK_ASSIGN;
						bin_index <= stat.best_idx;
						bin_count <= '0;
						last_bin <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				ST_BINS: begin
					if (out_free) begin
						out_valid <= 1'b1;
						result_kind <= nch_pkg::RK_BIN;
						bin_index <= c_q;
						bin_count <= stat.bin_rd;
						last_bin <= (c_q == nc_last);
						if (c_q == nc_last) begin
							seen_q <= '0;
							state_q <= ST_IDLE;
						end else c_q <= c_q + 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (state_q == ST_IDLE) count_q <= seen_q < max_descriptors;
		end
	end
endmodule

// File: rtl/nearest_center_histogram_unit.sv
// Top level: nearest-center histogram unit with configuration registers.
// Load and plain descriptor elements are stored on acceptance; a last element starts a
// search on the single shared MAC unit; input stalls until its assignment is emitted.
// End of image emits nc bins, one per cycle while the output is free.
// Reset clears histogram, descriptor count and configuration (50, 128, 200);
// center table and descriptor buffer are undefined until written.
`timescale 1ns / 1ps
module nearest_center_histogram_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [1:0] req_type,
	input  logic [5:0] center_index,
	input  logic [6:0] dim_index,
	input  logic [15:0] element_value,
	input  logic last_element,
	output logic out_valid,
	input  logic out_stall,
	output logic result_kind,
	output logic [5:0] bin_index,
	output logic [9:0] bin_count,
	output logic last_bin,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [15:0] cfg_data
);
	logic [6:0] active_clusters_q;
	logic [7:0] descriptor_dims_q;
	logic [9:0] max_descriptors_q;
	nch_pkg::nch_cmd_t cmd;
	nch_pkg::nch_stat_t stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_clusters_q <= 7'd50;
			descriptor_dims_q <= 8'd128;
			max_descriptors_q <= 10'd200;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				nch_pkg::CFG_CLUSTERS: active_clusters_q <= cfg_data[6:0];
				nch_pkg::CFG_DIMS: descriptor_dims_q <= cfg_data[7:0];
				nch_pkg::CFG_MAXDESC: max_descriptors_q <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	nch_control u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .req_type,
		.last_element,
		.active_clusters(active_clusters_q),
		.descriptor_dims(descriptor_dims_q),
		.max_descriptors(max_descriptors_q),
		.cmd, .stat, .out_valid, .out_stall, .result_kind, .bin_index, .bin_count,
		.last_bin
	);

	nch_datapath u_dp (
		.clk, .arst_n, .cmd,
		.ld_cidx(center_index),
		.ld_didx(dim_index),
		.ld_value(element_value),
		.stat
	);
endmodule
